// ----- rtl/itsp_pkg.sv -----
// ----------------------------------------------------------------------------
// itsp_pkg - shared types and constants for inductive track steering
// Holds the sizing constants, register indexes and the controller command
// word that links the sequencer to the datapath.
// ----------------------------------------------------------------------------
package itsp_pkg;

  localparam int ADC_BITS   = 12;
  localparam int WINDOW_LEN = 6;

  localparam int GAIN_W   = 10;
  localparam int WEIGHT_W = 9;

  // trimmed sum of three samples, window position and window total
  localparam int TRIM_W = $clog2(3 * ((1 << ADC_BITS) - 1) + 1);
  localparam int WPOS_W = $clog2(WINDOW_LEN);
  localparam int WSUM_W = $clog2(WINDOW_LEN * 3 * ((1 << ADC_BITS) - 1) + 1);

  // weighted sums, ratio numerator and denominator
  localparam int LSUM_W  = WEIGHT_W + WSUM_W;
  localparam int RSUM_W  = WSUM_W + 8;
  localparam int DIFF_W  = LSUM_W;
  localparam int SCALE   = 25600;
  localparam int SCALE_W = 15;
  localparam int NUM_W   = DIFF_W + SCALE_W;
  localparam int BIAS    = 768 * WINDOW_LEN;
  localparam int DEN_W   = LSUM_W + 1;

  // |ratio| <= 25600 < 2^15, so fifteen quotient bits suffice
  localparam int Q_W      = 15;
  localparam int QCNT_W   = $clog2(Q_W);
  localparam int RATIO_W  = 16;
  localparam int DRIVE_W  = 17;
  localparam int DRIVE_LIMIT = 65535;

  // PD products and their sum
  localparam int PP_W    = GAIN_W + 1 + RATIO_W;
  localparam int DP_W    = GAIN_W + 1 + RATIO_W + 1;
  localparam int PDSUM_W = DP_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_WEIGHT = 2'd2;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 10'd8;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 10'd270;
  localparam logic [WEIGHT_W-1:0] LEFT_WEIGHT_RST = 9'd205;

  typedef struct packed {
    logic load_in;
    logic win_wr;
    logic lsum_ld;
    logic num_ld;
    logic div_init;
    logic div_step;
    logic ratio_ld;
    logic pd_ld;
    logic out_ld;
  } dp_cmd_t;

endpackage

// ----- rtl/itsp_cfg.sv -----
// ----------------------------------------------------------------------------
// itsp_cfg - configuration registers
// Three gain and weight registers behind a simple APB-style slave.
// ----------------------------------------------------------------------------
module itsp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [itsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [itsp_pkg::GAIN_W-1:0]     prop_gain,
  output logic [itsp_pkg::GAIN_W-1:0]     deriv_gain,
  output logic [itsp_pkg::WEIGHT_W-1:0]   left_weight_q8
);
  import itsp_pkg::*;

  logic [GAIN_W-1:0]    prop_r, deriv_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r   <= PROP_GAIN_RST;
      deriv_r  <= DERIV_GAIN_RST;
      weight_r <= LEFT_WEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:   prop_r   <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_r  <= pwdata[GAIN_W-1:0];
        REG_LEFT_WEIGHT: weight_r <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP_GAIN:   prdata = 32'(prop_r);
      REG_DERIV_GAIN:  prdata = 32'(deriv_r);
      REG_LEFT_WEIGHT: prdata = 32'(weight_r);
      default:         prdata = '0;
    endcase
  end

  assign prop_gain      = prop_r;
  assign deriv_gain     = deriv_r;
  assign left_weight_q8 = weight_r;

endmodule

// ----- rtl/itsp_dpath.sv -----
// ----------------------------------------------------------------------------
// itsp_dpath - steering datapath
// Trimmed sums, moving window totals, weighted ratio by restoring division
// and the PD law with saturation. Every step is enabled by the controller.
// ----------------------------------------------------------------------------
module itsp_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  itsp_pkg::dp_cmd_t                   cmd,
  input  logic [itsp_pkg::GAIN_W-1:0]         prop_gain,
  input  logic [itsp_pkg::GAIN_W-1:0]         deriv_gain,
  input  logic [itsp_pkg::WEIGHT_W-1:0]       left_weight_q8,
  input  logic [5*itsp_pkg::ADC_BITS-1:0]     left_samples,
  input  logic [5*itsp_pkg::ADC_BITS-1:0]     right_samples,
  output logic signed [itsp_pkg::DRIVE_W-1:0] turn_drive,
  output logic signed [itsp_pkg::RATIO_W-1:0] position_ratio
);
  import itsp_pkg::*;

  localparam int TOT_W = ADC_BITS + 3;
  localparam int QD_W  = PDSUM_W - 8;
  localparam logic signed [QD_W-1:0] LIM_POS = QD_W'(DRIVE_LIMIT);
  localparam logic signed [QD_W-1:0] LIM_NEG = -QD_W'(DRIVE_LIMIT);

  // sum of five samples less one copy of the largest and of the smallest
  function automatic logic [TRIM_W-1:0] trim_sum(input logic [5*ADC_BITS-1:0] s);
    logic [TOT_W-1:0]    total;
    logic [ADC_BITS-1:0] hi, lo, v;
    total = '0;
    hi    = '0;
    lo    = '1;
    for (int k = 0; k < 5; k++) begin
      v     = s[k*ADC_BITS +: ADC_BITS];
      total = total + TOT_W'(v);
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
    return TRIM_W'(total - TOT_W'(hi) - TOT_W'(lo));
  endfunction

  logic [TRIM_W-1:0]         trim_l_r, trim_r_r;
  logic [TRIM_W-1:0]         win_l_r [WINDOW_LEN];
  logic [TRIM_W-1:0]         win_r_r [WINDOW_LEN];
  logic [WPOS_W-1:0]         pos_r;
  logic [WSUM_W-1:0]         wl_r, wr_r;
  logic [LSUM_W-1:0]         lsum_r;
  logic [RSUM_W-1:0]         rsum_r;
  logic                      neg_r;
  logic [NUM_W-1:0]          num_r;
  logic [DEN_W-1:0]          den_r, rem_r;
  logic [Q_W-1:0]            nq_r;
  logic signed [RATIO_W-1:0] ratio_r, prev_r, ratio_out_r;
  logic signed [PP_W-1:0]    pp_r;
  logic signed [DP_W-1:0]    dp_r;
  logic signed [DRIVE_W-1:0] drive_r;

  logic [DIFF_W-1:0]         mag;
  logic [DEN_W:0]            trial;
  logic                      ge;
  logic signed [RATIO_W-1:0] qv;
  logic signed [RATIO_W:0]   dratio;
  logic signed [PDSUM_W-1:0] pdsum, pdadj;
  logic signed [QD_W-1:0]    pdq;
  logic signed [DRIVE_W-1:0] drive_nxt;

  // magnitude of L - R, sign kept apart
  assign mag = (lsum_r < LSUM_W'(rsum_r)) ? DIFF_W'(LSUM_W'(rsum_r) - lsum_r)
                                          : DIFF_W'(lsum_r - LSUM_W'(rsum_r));

  assign trial = {rem_r, nq_r[Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign qv    = $signed({1'b0, nq_r});

  assign dratio = $signed({ratio_r[RATIO_W-1], ratio_r}) - $signed({prev_r[RATIO_W-1], prev_r});

  // truncate toward zero, then clamp
  assign pdsum = PDSUM_W'(pp_r) + PDSUM_W'(dp_r);
  assign pdadj = pdsum + (pdsum[PDSUM_W-1] ? PDSUM_W'(255) : PDSUM_W'(0));
  assign pdq   = QD_W'(pdadj >>> 8);

  always_comb begin
    priority if (pdq > LIM_POS) drive_nxt = DRIVE_W'(LIM_POS);
    else if (pdq < LIM_NEG)     drive_nxt = DRIVE_W'(LIM_NEG);
    else                        drive_nxt = DRIVE_W'(pdq);
  end

  // window store and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        win_l_r[k] <= '0;
        win_r_r[k] <= '0;
      end
      pos_r  <= '0;
      wl_r   <= '0;
      wr_r   <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.win_wr) begin
        win_l_r[pos_r] <= trim_l_r;
        win_r_r[pos_r] <= trim_r_r;
        wl_r  <= wl_r + WSUM_W'(trim_l_r) - WSUM_W'(win_l_r[pos_r]);
        wr_r  <= wr_r + WSUM_W'(trim_r_r) - WSUM_W'(win_r_r[pos_r]);
        pos_r <= (pos_r == WPOS_W'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;
      end
      if (cmd.out_ld) prev_r <= ratio_r;
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      trim_l_r <= trim_sum(left_samples);
      trim_r_r <= trim_sum(right_samples);
    end
    if (cmd.lsum_ld) begin
      lsum_r <= LSUM_W'(left_weight_q8) * LSUM_W'(wl_r);
      rsum_r <= {wr_r, 8'd0};
    end
    if (cmd.num_ld) begin
      neg_r <= lsum_r < LSUM_W'(rsum_r);
      num_r <= NUM_W'(SCALE) * NUM_W'(mag);
      den_r <= DEN_W'(lsum_r) + DEN_W'(rsum_r) + DEN_W'(BIAS);
    end
    if (cmd.div_init) begin
      rem_r <= DEN_W'(num_r[NUM_W-1:Q_W]);
      nq_r  <= num_r[Q_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      nq_r  <= {nq_r[Q_W-2:0], ge};
    end
    if (cmd.ratio_ld) ratio_r <= neg_r ? -qv : qv;
    if (cmd.pd_ld) begin
      pp_r <= $signed({1'b0, prop_gain}) * ratio_r;
      dp_r <= $signed({1'b0, deriv_gain}) * dratio;
    end
    if (cmd.out_ld) begin
      drive_r     <= drive_nxt;
      ratio_out_r <= ratio_r;
    end
  end

  assign turn_drive     = drive_r;
  assign position_ratio = ratio_out_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < den_r)
    else $error("division remainder not below divisor");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ratio_ld |=> (ratio_r <= 16'sd25600) && (ratio_r >= -16'sd25600))
    else $error("position ratio out of range");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> (drive_r <= 17'sd65535) && (drive_r >= -17'sd65535))
    else $error("turn drive not saturated");

endmodule

// ----- rtl/itsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// itsp_ctrl - sequencer
// Steps one word through trim, window, weighted sum, division, ratio and PD
// stages and owns both handshakes.
// ----------------------------------------------------------------------------
module itsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output itsp_pkg::dp_cmd_t cmd
);
  import itsp_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WIN   = 4'd1;
  localparam logic [3:0] ST_LSUM  = 4'd2;
  localparam logic [3:0] ST_NUM   = 4'd3;
  localparam logic [3:0] ST_DINIT = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_RATIO = 4'd6;
  localparam logic [3:0] ST_PD    = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc, out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.win_wr = 1'b1;
        state_nxt  = ST_LSUM;
      end
      ST_LSUM: begin
        cmd.lsum_ld = 1'b1;
        state_nxt   = ST_NUM;
      end
      ST_NUM: begin
        cmd.num_ld = 1'b1;
        state_nxt  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == QCNT_W'(Q_W - 1)) state_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        cmd.ratio_ld = 1'b1;
        state_nxt    = ST_PD;
      end
      ST_PD: begin
        cmd.pd_ld = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.out_ld)           out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else                               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_WIN)
    else $error("accepted word did not start the sequence");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_ld))
    else $error("result valid without a load");

endmodule

// ----- rtl/inductive_track_steering_pd.sv -----
// ----------------------------------------------------------------------------
// inductive_track_steering_pd - PD steering from two track-sensing coils
// Trimmed-mean moving average per coil, weighted difference ratio and a
// proportional-derivative drive law.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word carries five 12-bit ADC
//   samples per coil. in_stall is low only while the sequencer is idle.
//   Result channel (out_valid / out_stall): one word per input word with the
//   saturated turn drive and the position ratio (percent, Q8).
//   The next word is taken the cycle after the result is loaded; the sequencer
//   takes no new word until it is through with the last one. The fifteen-step
//   restoring divider for the ratio is the longest part of the sequence.
//   A result waiting on out_stall does not block acceptance of the next word;
//   the sequencer holds only if a new result is ready and the old one has not
//   been taken.
//   Reset (rst_n low, synchronous): window cleared, previous ratio zero, gains
//   back to 8 / 270 and left weight to 205. Write configuration only while
//   idle, through the APB-style port (pready always high).
// ----------------------------------------------------------------------------
module inductive_track_steering_pd (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [itsp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_left_sample_a,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_left_sample_b,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_left_sample_c,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_left_sample_d,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_left_sample_e,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_right_sample_a,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_right_sample_b,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_right_sample_c,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_right_sample_d,
  input  logic [itsp_pkg::ADC_BITS-1:0]       in_right_sample_e,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [itsp_pkg::DRIVE_W-1:0] out_turn_drive,
  output logic signed [itsp_pkg::RATIO_W-1:0] out_position_ratio
);
  import itsp_pkg::*;

  dp_cmd_t             cmd;
  logic [GAIN_W-1:0]   prop_gain, deriv_gain;
  logic [WEIGHT_W-1:0] left_weight_q8;

  // configuration registers
  itsp_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .prop_gain      (prop_gain),
    .deriv_gain     (deriv_gain),
    .left_weight_q8 (left_weight_q8)
  );

  // sequencer: handshakes and step enables
  itsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: samples packed with sample a in the low bits
  itsp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .prop_gain      (prop_gain),
    .deriv_gain     (deriv_gain),
    .left_weight_q8 (left_weight_q8),
    .left_samples   ({in_left_sample_e, in_left_sample_d, in_left_sample_c,
                      in_left_sample_b, in_left_sample_a}),
    .right_samples  ({in_right_sample_e, in_right_sample_d, in_right_sample_c,
                      in_right_sample_b, in_right_sample_a}),
    .turn_drive     (out_turn_drive),
    .position_ratio (out_position_ratio)
  );

endmodule

// ----- tb/steering_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steering_drive_checker - predicts and checks the steering result words
// Tracks register writes on the configuration port, keeps its own trimmed-sum
// windows and previous ratio, and compares each accepted result word with the
// oldest prediction.
// ----------------------------------------------------------------------------
module steering_drive_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [itsp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [4:0][itsp_pkg::ADC_BITS-1:0]   left_samples,
  input  logic [4:0][itsp_pkg::ADC_BITS-1:0]   right_samples,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [itsp_pkg::DRIVE_W-1:0]  turn_drive,
  input  logic signed [itsp_pkg::RATIO_W-1:0]  position_ratio,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   results_seen
);
  import itsp_pkg::*;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [RATIO_W-1:0] ratio;
  } steer_result_t;

  steer_result_t steer_due[$];

  logic [TRIM_W-1:0]   left_window [WINDOW_LEN];
  logic [TRIM_W-1:0]   right_window[WINDOW_LEN];
  int                  slot;
  longint              last_ratio;
  logic [GAIN_W-1:0]   prop_gain_q;
  logic [GAIN_W-1:0]   deriv_gain_q;
  logic [WEIGHT_W-1:0] left_weight_q;

  int fail_count = 0;
  int backlog    = 0;
  int seen_count = 0;

  assign mismatches   = fail_count;
  assign outstanding  = backlog;
  assign results_seen = seen_count;

  // sum of five samples less one copy of the largest and one of the smallest
  function automatic logic [TRIM_W-1:0] trimmed_sum(input logic [4:0][ADC_BITS-1:0] s);
    int total;
    int hi;
    int lo;
    int k;
    total = 0;
    hi    = 0;
    lo    = (1 << ADC_BITS) - 1;
    for (k = 0; k < 5; k++) begin
      total += int'(s[k]);
      if (int'(s[k]) > hi) hi = int'(s[k]);
      if (int'(s[k]) < lo) lo = int'(s[k]);
    end
    return TRIM_W'(total - hi - lo);
  endfunction

  task automatic report_mismatch(input string note);
    fail_count++;
    if (fail_count <= 50) $display("%t drive check: %s", $time, note);
  endtask

  always @(posedge clk) begin
    longint        wl;
    longint        wr;
    longint        lsum;
    longint        rsum;
    longint        ratio;
    longint        drive;
    steer_result_t want;
    int            k;
    if (!rst_n) begin
      for (k = 0; k < WINDOW_LEN; k++) begin
        left_window[k]  = '0;
        right_window[k] = '0;
      end
      slot          = 0;
      last_ratio    = 0;
      prop_gain_q   = PROP_GAIN_RST;
      deriv_gain_q  = DERIV_GAIN_RST;
      left_weight_q = LEFT_WEIGHT_RST;
      steer_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_PROP_GAIN:   prop_gain_q   = pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN:  deriv_gain_q  = pwdata[GAIN_W-1:0];
          REG_LEFT_WEIGHT: left_weight_q = pwdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        left_window[slot]  = trimmed_sum(left_samples);
        right_window[slot] = trimmed_sum(right_samples);
        slot = (slot + 1) % WINDOW_LEN;
        wl = 0;
        wr = 0;
        for (k = 0; k < WINDOW_LEN; k++) begin
          wl += longint'(left_window[k]);
          wr += longint'(right_window[k]);
        end
        lsum  = longint'(left_weight_q) * wl;
        rsum  = 256 * wr;
        ratio = (longint'(SCALE) * (lsum - rsum)) / (lsum + rsum + longint'(BIAS));
        drive = (longint'(prop_gain_q) * ratio
                 + longint'(deriv_gain_q) * (ratio - last_ratio)) / 256;
        if (drive > DRIVE_LIMIT)  drive = DRIVE_LIMIT;
        if (drive < -DRIVE_LIMIT) drive = -DRIVE_LIMIT;
        last_ratio = ratio;
        want.drive = drive[DRIVE_W-1:0];
        want.ratio = ratio[RATIO_W-1:0];
        steer_due.push_back(want);
      end

      if (out_valid && !out_stall) begin
        seen_count++;
        if (steer_due.size() == 0) begin
          report_mismatch($sformatf("result word with none expected (drive %0d)",
                                    turn_drive));
        end else begin
          want = steer_due.pop_front();
          if (turn_drive !== want.drive)
            report_mismatch($sformatf("turn_drive %0d, want %0d", turn_drive,
                                      $signed(want.drive)));
          if (position_ratio !== want.ratio)
            report_mismatch($sformatf("position_ratio %0d, want %0d", position_ratio,
                                      $signed(want.ratio)));
        end
      end
    end
    backlog = steer_due.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for inductive_track_steering_pd
// Drives directed and random sample words under random idling and stalls,
// steps through several gain and weight settings written over the
// configuration port, and leaves prediction and checking to the checker.
// ----------------------------------------------------------------------------
module tb;
  import itsp_pkg::*;

  typedef logic [4:0][ADC_BITS-1:0] coil_t;

  localparam logic [ADC_BITS-1:0]  SAMPLE_MAX   = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 148;
  localparam int DIRECTED    = 16;
  localparam int LATENCY     = 22;

  logic clk;

  // every block input is held at a known value from time zero
  logic                  rst_n     = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  coil_t                 in_left   = '0;
  coil_t                 in_right  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_turn_drive;
  logic signed [RATIO_W-1:0] out_position_ratio;

  int mismatches;
  int outstanding;
  int results_seen;

  // chance in percent that either side idles; zero in the calm stretch
  int idle_pct   = 35;
  int stall_left = 0;
  int words_sent = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  inductive_track_steering_pd dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_sample_a   (in_left[0]),
    .in_left_sample_b   (in_left[1]),
    .in_left_sample_c   (in_left[2]),
    .in_left_sample_d   (in_left[3]),
    .in_left_sample_e   (in_left[4]),
    .in_right_sample_a  (in_right[0]),
    .in_right_sample_b  (in_right[1]),
    .in_right_sample_c  (in_right[2]),
    .in_right_sample_d  (in_right[3]),
    .in_right_sample_e  (in_right[4]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_turn_drive     (out_turn_drive),
    .out_position_ratio (out_position_ratio)
  );

  steering_drive_checker drive_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .left_samples   (in_left),
    .right_samples  (in_right),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .turn_drive     (out_turn_drive),
    .position_ratio (out_position_ratio),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen)
  );

  // Result side: stall at random, now and then for a long burst so that the
  // next result is ready before the previous one has been taken.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40) : 0;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Five samples spread around a centre, clipped to the ADC range.
  function automatic coil_t noisy_coil(input int centre, input int spread);
    coil_t c;
    int    v;
    int    k;
    for (k = 0; k < 5; k++) begin
      v = centre + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
      c[k] = v[ADC_BITS-1:0];
    end
    return c;
  endfunction

  // Offer one word; hold it until the block takes it. Entered and left on a
  // rising edge, so valid stays high across back-to-back words.
  task automatic send_word(input coil_t left, input coil_t right);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left  <= left;
    in_right <= right;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // Setup then access phase; then idle with psel low before returning, so
  // psel never toggles twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    coil_t               l;
    coil_t               r;
    int                  i;
    int                  p;
    int                  k;
    int                  track;
    logic [ADC_BITS-1:0] tie_val;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   kd;
    logic [WEIGHT_W-1:0] wt;

    track = 2048;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at reset settings: the first five see a window that is
    // not yet full, then one-sided coils, ties and large ratio swings.
    for (i = 0; i < DIRECTED; i++) begin
      case (i)
        0: begin
          l = '0;
          r = '0;
        end
        1: begin
          l = {5{SAMPLE_MAX}};
          r = '0;
        end
        2: begin
          l = '0;
          r = {5{SAMPLE_MAX}};
        end
        3: begin
          l = {SAMPLE_MAX, 12'h000, SAMPLE_MAX, 12'h000, 12'h800};
          r = {5{12'd1000}};
        end
        4: begin
          l = {5{12'd1000}};
          r = {12'h000, SAMPLE_MAX, 12'h7FF, 12'h000, SAMPLE_MAX};
        end
        5: begin
          l = {12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA};
          r = {12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555};
        end
        6: begin
          l = {12'd5, 12'd4, 12'd3, 12'd2, 12'd1};
          r = {12'd1, 12'd2, 12'd3, 12'd4, 12'd5};
        end
        7: begin
          l = {SAMPLE_MAX, 12'd1, 12'd1, 12'd1, 12'd1};
          r = {12'd0, 12'hFFE, 12'hFFE, 12'hFFE, 12'hFFE};
        end
        8, 10, 12: begin
          l = {5{SAMPLE_MAX}};
          r = '0;
        end
        9, 11, 13: begin
          l = '0;
          r = {5{SAMPLE_MAX}};
        end
        default: begin
          l = noisy_coil(3000, 1000);
          r = noisy_coil(1000, 1000);
        end
      endcase
      send_word(l, r);
    end

    for (p = 0; p < PHASES; p++) begin
      drain();

      // Extremes first, then the reset values again, then random settings.
      case (p)
        0: begin kp = '1;       kd = '1;        wt = 9'd256;          end
        1: begin kp = '0;       kd = '0;        wt = '0;              end
        2: begin kp = '1;       kd = '0;        wt = '1;              end
        3: begin kp = '0;       kd = '1;        wt = 9'd1;            end
        4: begin kp = PROP_GAIN_RST; kd = DERIV_GAIN_RST; wt = LEFT_WEIGHT_RST; end
        default: begin
          kp = GAIN_W'($urandom_range(1023));
          kd = GAIN_W'($urandom_range(1023));
          wt = ($urandom_range(3) == 0) ? WEIGHT_W'($urandom_range(511))
                                        : WEIGHT_W'($urandom_range(256));
        end
      endcase

      // Junk in the bits above each register's width must be dropped, and a
      // write beyond the register list must change nothing.
      write_reg(REG_PROP_GAIN,   ($urandom << GAIN_W) | 32'(kp));
      write_reg(REG_DERIV_GAIN,  ($urandom << GAIN_W) | 32'(kd));
      write_reg(REG_LEFT_WEIGHT, ($urandom << WEIGHT_W) | 32'(wt));
      write_reg(REG_UNMAPPED,    $urandom);

      // one phase runs without any idling on either side
      idle_pct = (p == 5) ? 0 : 35;

      for (i = 0; i < PHASE_WORDS; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            l = noisy_coil(2048, 2048);
            r = noisy_coil(2048, 2048);
          end
          4, 5: begin
            // nearly balanced coils keep the ratio close to zero
            k = $urandom_range(int'(SAMPLE_MAX));
            l = noisy_coil(k, 40);
            r = noisy_coil(k, 40);
          end
          6: begin
            l = noisy_coil(int'(SAMPLE_MAX), 300);
            r = noisy_coil(0, 300);
            if ($urandom_range(1)) begin
              r = l;
              l = noisy_coil(0, 300);
            end
          end
          7: begin
            // heavy ties: samples drawn from three values only
            tie_val = ADC_BITS'($urandom_range(int'(SAMPLE_MAX)));
            for (k = 0; k < 5; k++) begin
              l[k] = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) ? SAMPLE_MAX : tie_val);
              r[k] = ($urandom_range(2) == 0) ? '0 : ($urandom_range(1) ? SAMPLE_MAX : tie_val);
            end
          end
          default: begin
            // the car drifting across the track
            track = track + int'($urandom_range(400)) - 200;
            if (track < 0) track = 0;
            if (track > int'(SAMPLE_MAX)) track = int'(SAMPLE_MAX);
            l = noisy_coil(track, 100);
            r = noisy_coil(int'(SAMPLE_MAX) - track, 100);
          end
        endcase
        send_word(l, r);
      end
      idle_pct = 35;
    end

    drain();
    repeat (LATENCY + 7) @(posedge clk);

    $display("tb: %0d sample words driven over %0d register settings plus reset values",
             words_sent, PHASES);
    $display("tb: %0d result words compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
